@@ rtl/rbpu_pkg.sv @@
// Shared types, constants and helper functions for the rotating-body particle update unit.
// Used by rbpu_bitmap, rbpu_alu and the top level; depends on nothing.
package rbpu_pkg;

  localparam int ID_W   = 12;
  localparam int DATA_W = 32;
  localparam int PROD_W = 64;
  localparam int ACC_W  = 65;
  localparam int SUM_W  = 52;

  localparam logic signed [ACC_W-1:0] RND_Q30 = 65'sd536870912;
  localparam logic signed [ACC_W-1:0] RND_Q16 = 65'sd32768;

  typedef enum logic [2:0] {
    ACT_ADD      = 3'd0,
    ACT_REMOVE   = 3'd1,
    ACT_POSITION = 3'd2,
    ACT_VELOCITY = 3'd3,
    ACT_ENERGY   = 3'd4,
    ACT_INTERACT = 3'd5,
    ACT_CONTEXT  = 3'd6,
    ACT_NEW_STEP = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_ROT_M00  = 3'd2,
    REG_ROT_M01  = 3'd3,
    REG_ROT_M10  = 3'd4,
    REG_ROT_M11  = 3'd5,
    REG_OMEGA    = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    MSRC_M00   = 3'd0,
    MSRC_M01   = 3'd1,
    MSRC_M10   = 3'd2,
    MSRC_M11   = 3'd3,
    MSRC_OMEGA = 3'd4
  } mul_src_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] center_x;
    logic signed [DATA_W-1:0] center_y;
    logic signed [DATA_W-1:0] m00;
    logic signed [DATA_W-1:0] m01;
    logic signed [DATA_W-1:0] m10;
    logic signed [DATA_W-1:0] m11;
    logic signed [DATA_W-1:0] omega;
  } cfg_t;

  typedef struct packed {
    mul_src_t a_sel;
    logic     b_dy;
    acc_op_t  acc_op;
    logic     q30;
    logic     fin_y;
    logic     neg;
  } alu_ctl_t;

  typedef struct packed {
    logic rd_en;
    logic member_we;
    logic member_wd;
    logic moved_we;
    logic moved_wd;
  } bm_ctl_t;

  function automatic logic signed [SUM_W-1:0] ext_sum(input logic signed [DATA_W-1:0] v);
    return {{(SUM_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-DATA_W:0] up;
    up = v[SUM_W-1:DATA_W-1];
    if ((&up) || !(|up)) return v[DATA_W-1:0];
    else if (v[SUM_W-1]) return {1'b1, {(DATA_W-1){1'b0}}};
    else return {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

endpackage

@@ rtl/rbpu_bitmap.sv @@
// Membership and moved-this-step bitmaps, one bit per particle, one read and one write port.
// Depends on rbpu_pkg for the port control struct.
module rbpu_bitmap import rbpu_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  bm_ctl_t       ctl,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] wr_addr,
  output logic          member_q,
  output logic          moved_q
);

  logic mem_member [DEPTH];
  logic mem_moved  [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.member_we) begin
      mem_member[wr_addr] <= ctl.member_wd;
    end
    if (ctl.moved_we) begin
      mem_moved[wr_addr] <= ctl.moved_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      member_q <= mem_member[rd_addr];
      moved_q  <= mem_moved[rd_addr];
    end
  end

endmodule

@@ rtl/rbpu_alu.sv @@
// Shared multiply-accumulate unit: offset saturation, one 32x32 multiplier, a rounding
// accumulator and the final shift, center add and saturation. Depends on rbpu_pkg.
module rbpu_alu import rbpu_pkg::*; (
  input  logic                     clk,
  input  cfg_t                     cfg,
  input  alu_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] cur_x,
  input  logic signed [DATA_W-1:0] cur_y,
  output logic signed [DATA_W-1:0] fin
);

  logic signed [DATA_W-1:0] dx;
  logic signed [DATA_W-1:0] dy;
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  sh;
  logic signed [SUM_W-1:0]  t;
  logic signed [SUM_W-1:0]  base;
  logic signed [SUM_W-1:0]  sum;

  always_comb begin
    unique case (ctl.a_sel)
      MSRC_M00: mul_a = cfg.m00;
      MSRC_M01: mul_a = cfg.m01;
      MSRC_M10: mul_a = cfg.m10;
      MSRC_M11: mul_a = cfg.m11;
      default:  mul_a = cfg.omega;
    endcase
    mul_b    = ctl.b_dy ? dy : dx;
    prod_ext = {prod[PROD_W-1], prod};
    rnd      = ctl.q30 ? RND_Q30 : RND_Q16;
    sh       = ctl.q30 ? (acc >>> 30) : (acc >>> 16);
    t        = sh[SUM_W-1:0];
    base     = ctl.q30 ? ext_sum(ctl.fin_y ? cfg.center_y : cfg.center_x) : '0;
    sum      = ctl.neg ? (base - t) : (base + t);
    fin      = sat32(sum);
  end

  always_ff @(posedge clk) begin
    dx   <= sat32(ext_sum(cur_x) - ext_sum(cfg.center_x));
    dy   <= sat32(ext_sum(cur_y) - ext_sum(cfg.center_y));
    prod <= mul_a * mul_b;
    unique case (ctl.acc_op)
      ACC_LOAD: acc <= prod_ext + rnd;
      ACC_ADD:  acc <= acc + prod_ext;
      default:  acc <= acc;
    endcase
  end

endmodule

@@ rtl/rotating_body_particle_update_unit.sv @@
// Rotating-body particle update unit: top level with sequencer, register file and output stage.
// Depends on rbpu_pkg, rbpu_bitmap and rbpu_alu.
//
// Usage: a request (action, ids, flag, position, velocity, energy fields) enters on
// item_valid/item_stall; exactly one result leaves on result_valid/result_stall. Registers
// are to be written over the APB-style port while the unit is idle (not enforced by the unit);
// One request is worked at a time through a shared multiplier and one bitmap port:
//   add, remove, energy, context, ordinary position or velocity: one bitmap read;
//   interact query: a second bitmap read, for the other particle;
//   velocity of a rotating particle: two multiplies after the read;
//   position of a rotating particle not yet moved: four multiplies after the read;
//   new step: the one-entry-per-cycle sweep of the moved bitmap after the read.
// pready is always high. A new request is taken only once the previous result has entered
// the output register.
// Reset: the unit sweeps every entry of both bitmaps with item_stall high;
// registers return to an identity matrix, zero center and zero omega.
// A stalled result stays in the output register; the next request is still accepted and
// worked, and waits at its end until the output register frees.
module rotating_body_particle_update_unit import rbpu_pkg::*; #(
  parameter int MAX_PARTICLES = 4096
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [4:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [2:0]               action,
  input  logic [ID_W-1:0]          particle_id,
  input  logic [ID_W-1:0]          other_id,
  input  logic                     rotating_flag,
  input  logic signed [DATA_W-1:0] cur_x,
  input  logic signed [DATA_W-1:0] cur_y,
  input  logic signed [DATA_W-1:0] new_x,
  input  logic signed [DATA_W-1:0] new_y,
  input  logic signed [DATA_W-1:0] new_vx,
  input  logic signed [DATA_W-1:0] new_vy,
  input  logic signed [DATA_W-1:0] new_energy,
  input  logic signed [DATA_W-1:0] old_energy,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [DATA_W-1:0] pos_x,
  output logic signed [DATA_W-1:0] pos_y,
  output logic signed [DATA_W-1:0] vel_x,
  output logic signed [DATA_W-1:0] vel_y,
  output logic signed [DATA_W-1:0] energy_out,
  output logic                     is_rotating,
  output logic                     may_interact,
  output logic                     context_code
);

  localparam int AW = $clog2(MAX_PARTICLES);
  localparam int CW = ((AW > ID_W) ? AW : ID_W) + 1;
  localparam logic [AW-1:0] LAST_IDX  = AW'(MAX_PARTICLES - 1);
  localparam logic [CW-1:0] DEPTH_CMP = CW'(MAX_PARTICLES);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_LOOK  = 11'b000_0000_0100,
    S_OTHER = 11'b000_0000_1000,
    S_M0    = 11'b000_0001_0000,
    S_M1    = 11'b000_0010_0000,
    S_M2    = 11'b000_0100_0000,
    S_M3    = 11'b000_1000_0000,
    S_M4    = 11'b001_0000_0000,
    S_M5    = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;
  logic [AW-1:0] clr_cnt;
  logic          clr_member;

  cfg_t cfg;

  action_t                  act_q;
  logic [ID_W-1:0]          id_q;
  logic [ID_W-1:0]          other_q;
  logic                     flag_q;
  logic signed [DATA_W-1:0] cur_x_q, cur_y_q, new_x_q, new_y_q;
  logic signed [DATA_W-1:0] new_vx_q, new_vy_q, new_e_q, old_e_q;

  logic signed [DATA_W-1:0] px, py, vx, vy, en;
  logic                     rot, inter, mem_id;

  bm_ctl_t       bm;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          member_q, moved_q;
  alu_ctl_t      ctl;
  logic signed [DATA_W-1:0] fin;

  logic id_ok, other_ok, look_member, is_pos, cfg_we, out_load;

  assign pready     = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign id_ok      = (CW'(id_q) < DEPTH_CMP);
  assign other_ok   = (CW'(other_q) < DEPTH_CMP);
  assign look_member = id_ok & member_q;
  assign is_pos     = (act_q == ACT_POSITION);
  assign cfg_we     = psel & penable & pwrite;
  assign out_load   = (state == S_DONE) && (!result_valid || !result_stall);
  assign context_code = is_rotating;

  rbpu_bitmap #(.DEPTH(MAX_PARTICLES), .AW(AW)) u_bitmap (
    .clk     (clk),
    .ctl     (bm),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .member_q(member_q),
    .moved_q (moved_q)
  );

  rbpu_alu u_alu (
    .clk  (clk),
    .cfg  (cfg),
    .ctl  (ctl),
    .cur_x(cur_x_q),
    .cur_y(cur_y_q),
    .fin  (fin)
  );

  always_comb begin
    state_next = state;
    bm         = '0;
    rd_addr    = AW'(particle_id);
    wr_addr    = AW'(id_q);
    ctl        = '{a_sel: MSRC_M00, b_dy: 1'b0, acc_op: ACC_HOLD,
                   q30: 1'b0, fin_y: 1'b0, neg: 1'b0};
    unique case (state)
      S_CLEAR: begin
        wr_addr      = clr_cnt;
        bm.moved_we  = 1'b1;
        bm.member_we = clr_member;
        if (clr_cnt == LAST_IDX) begin
          state_next = clr_member ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          bm.rd_en   = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        unique case (act_q)
          ACT_ADD: begin
            bm.member_we = id_ok & flag_q;
            bm.member_wd = 1'b1;
            state_next   = S_DONE;
          end
          ACT_REMOVE: begin
            bm.member_we = id_ok;
            state_next   = S_DONE;
          end
          ACT_POSITION: begin
            if (look_member && !moved_q) begin
              bm.moved_we = 1'b1;
              bm.moved_wd = 1'b1;
              state_next  = S_M0;
            end else begin
              state_next = S_DONE;
            end
          end
          ACT_VELOCITY: state_next = look_member ? S_M0 : S_DONE;
          ACT_ENERGY:   state_next = S_DONE;
          ACT_INTERACT: begin
            bm.rd_en   = 1'b1;
            rd_addr    = AW'(other_q);
            state_next = S_OTHER;
          end
          ACT_CONTEXT:  state_next = S_DONE;
          ACT_NEW_STEP: state_next = S_CLEAR;
        endcase
      end
      S_OTHER: state_next = S_DONE;
      S_M0: begin
        ctl.a_sel  = is_pos ? MSRC_M00 : MSRC_OMEGA;
        ctl.b_dy   = !is_pos;
        state_next = S_M1;
      end
      S_M1: begin
        ctl.a_sel  = is_pos ? MSRC_M01 : MSRC_OMEGA;
        ctl.b_dy   = is_pos;
        ctl.acc_op = ACC_LOAD;
        ctl.q30    = is_pos;
        state_next = S_M2;
      end
      S_M2: begin
        ctl.a_sel  = MSRC_M10;
        ctl.acc_op = is_pos ? ACC_ADD : ACC_LOAD;
        ctl.q30    = is_pos;
        ctl.neg    = !is_pos;
        state_next = S_M3;
      end
      S_M3: begin
        ctl.a_sel  = MSRC_M11;
        ctl.b_dy   = 1'b1;
        ctl.acc_op = is_pos ? ACC_LOAD : ACC_HOLD;
        ctl.q30    = is_pos;
        state_next = is_pos ? S_M4 : S_DONE;
      end
      S_M4: begin
        ctl.acc_op = ACC_ADD;
        ctl.q30    = 1'b1;
        state_next = S_M5;
      end
      S_M5: begin
        ctl.q30    = 1'b1;
        ctl.fin_y  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      clr_member   <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= (clr_cnt == LAST_IDX) ? '0 : clr_cnt + 1'b1;
      end
      if (state == S_LOOK && act_q == ACT_NEW_STEP) begin
        clr_member <= 1'b0;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x <= '0;
      cfg.center_y <= '0;
      cfg.m00      <= 32'sh4000_0000;
      cfg.m01      <= '0;
      cfg.m10      <= '0;
      cfg.m11      <= 32'sh4000_0000;
      cfg.omega    <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(paddr[4:2]))
        REG_CENTER_X: cfg.center_x <= pwdata;
        REG_CENTER_Y: cfg.center_y <= pwdata;
        REG_ROT_M00:  cfg.m00      <= pwdata;
        REG_ROT_M01:  cfg.m01      <= pwdata;
        REG_ROT_M10:  cfg.m10      <= pwdata;
        REG_ROT_M11:  cfg.m11      <= pwdata;
        REG_OMEGA:    cfg.omega    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      REG_CENTER_X: prdata = cfg.center_x;
      REG_CENTER_Y: prdata = cfg.center_y;
      REG_ROT_M00:  prdata = cfg.m00;
      REG_ROT_M01:  prdata = cfg.m01;
      REG_ROT_M10:  prdata = cfg.m10;
      REG_ROT_M11:  prdata = cfg.m11;
      REG_OMEGA:    prdata = cfg.omega;
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      act_q    <= action_t'(action);
      id_q     <= particle_id;
      other_q  <= other_id;
      flag_q   <= rotating_flag;
      cur_x_q  <= cur_x;
      cur_y_q  <= cur_y;
      new_x_q  <= new_x;
      new_y_q  <= new_y;
      new_vx_q <= new_vx;
      new_vy_q <= new_vy;
      new_e_q  <= new_energy;
      old_e_q  <= old_energy;
    end
    if (state == S_LOOK) begin
      mem_id <= look_member;
      px     <= '0;
      py     <= '0;
      vx     <= '0;
      vy     <= '0;
      en     <= '0;
      inter  <= 1'b0;
      rot    <= look_member;
      unique case (act_q)
        ACT_ADD:    rot <= look_member | (id_ok & flag_q);
        ACT_REMOVE: rot <= 1'b0;
        ACT_POSITION: begin
          if (!look_member) begin
            px <= new_x_q;
            py <= new_y_q;
          end else if (moved_q) begin
            px <= cur_x_q;
            py <= cur_y_q;
          end
        end
        ACT_VELOCITY: begin
          if (!look_member) begin
            vx <= new_vx_q;
            vy <= new_vy_q;
          end
        end
        ACT_ENERGY: en <= look_member ? old_e_q : new_e_q;
        ACT_INTERACT, ACT_CONTEXT, ACT_NEW_STEP: ;
      endcase
    end
    if (state == S_OTHER) begin
      inter <= !(mem_id & other_ok & member_q);
    end
    if (state == S_M2 && !is_pos) begin
      vx <= fin;
    end
    if (state == S_M3) begin
      if (is_pos) begin
        px <= fin;
      end else begin
        vy <= fin;
      end
    end
    if (state == S_M5) begin
      py <= fin;
    end
    if (out_load) begin
      pos_x        <= px;
      pos_y        <= py;
      vel_x        <= vx;
      vel_y        <= vy;
      energy_out   <= en;
      is_rotating  <= rot;
      may_interact <= inter;
    end
  end

endmodule

@@ rtl/rbpu_checker.sv @@
// Port-level checks for the rotating-body particle update unit, bound to its top level.
// Depends only on the top level's ports.
module rbpu_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [31:0] pos_x,
  input logic [31:0] pos_y,
  input logic        is_rotating,
  input logic        context_code
);

  logic [1:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = item_valid && !item_stall;
  assign out_acc = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 1'b1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> item_stall)
    else $error("request accepted while previous one in work");

  a_stalled_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(pos_x) && $stable(pos_y)))
    else $error("stalled result changed");

  a_result_has_request: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> (pending != 2'd0))
    else $error("result without request");

  a_context_matches: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (is_rotating == context_code))
    else $error("context code differs from membership");

endmodule

bind rotating_body_particle_update_unit rbpu_checker u_rbpu_checker (.*);

@@ verif/rotating_body_particle_update_unit_tb.sv @@
// Self-checking testbench for the rotating-body particle update unit: directed and random
// requests under several idle and stall patterns, with an in-bench predictor of every result.
// Depends on rbpu_pkg and the rotating_body_particle_update_unit RTL.
module rotating_body_particle_update_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rbpu_pkg::*;

  localparam int PARTICLE_COUNT = 4096;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam logic signed [31:0] Q_HI = 32'sh7fffffff;
  localparam logic signed [31:0] Q_LO = 32'sh80000000;

  typedef logic signed [79:0] wide_t;
  localparam wide_t W_HI = 80'sd2147483647;
  localparam wide_t W_LO = -80'sd2147483648;
  localparam wide_t HALF_Q30 = 80'sd536870912;
  localparam wide_t HALF_Q16 = 80'sd32768;

  typedef struct {
    action_t            action;
    logic [11:0]        particle_id;
    logic [11:0]        other_id;
    logic               rotating_flag;
    logic signed [31:0] cur_x, cur_y, new_x, new_y, new_vx, new_vy, new_energy, old_energy;
  } request_t;

  typedef struct {
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y, energy_out;
    logic               is_rotating, may_interact, context_code;
  } update_t;

  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [2:0] action = '0;
  logic [ID_W-1:0] particle_id = '0, other_id = '0;
  logic rotating_flag = 1'b0;
  logic signed [DATA_W-1:0] cur_x = '0, cur_y = '0, new_x = '0, new_y = '0;
  logic signed [DATA_W-1:0] new_vx = '0, new_vy = '0, new_energy = '0, old_energy = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [DATA_W-1:0] pos_x, pos_y, vel_x, vel_y, energy_out;
  logic is_rotating, may_interact, context_code;

  logic signed [31:0] ctr_x, ctr_y, m00, m01, m10, m11, omega;
  bit member_bits[PARTICLE_COUNT];
  bit moved_bits[PARTICLE_COUNT];
  update_t expected_updates[$];
  update_t want;
  int mismatches = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  logic [11:0] id_pool[16];

  rotating_body_particle_update_unit u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_stall(item_stall),
    .action(action), .particle_id(particle_id), .other_id(other_id),
    .rotating_flag(rotating_flag), .cur_x(cur_x), .cur_y(cur_y), .new_x(new_x), .new_y(new_y),
    .new_vx(new_vx), .new_vy(new_vy), .new_energy(new_energy), .old_energy(old_energy),
    .result_valid(result_valid), .result_stall(result_stall),
    .pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y), .energy_out(energy_out),
    .is_rotating(is_rotating), .may_interact(may_interact), .context_code(context_code)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic wide_t widen(input logic signed [31:0] v);
    return {{48{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] clamp32(input wide_t v);
    if (v > W_HI) return Q_HI;
    if (v < W_LO) return Q_LO;
    return v[31:0];
  endfunction

  function automatic wide_t rotate_row(input logic signed [31:0] a, x, b, y);
    wide_t sum;
    sum = widen(a) * widen(x) + widen(b) * widen(y);
    return (sum + HALF_Q30) >>> 30;
  endfunction

  function automatic wide_t scale_q16(input logic signed [31:0] a, b);
    return (widen(a) * widen(b) + HALF_Q16) >>> 16;
  endfunction

  function automatic update_t predict_update(input request_t r);
    update_t u;
    logic signed [31:0] dx, dy;
    logic rot;
    u = '{default: '0};
    rot = member_bits[r.particle_id];
    dx = clamp32(widen(r.cur_x) - widen(ctr_x));
    dy = clamp32(widen(r.cur_y) - widen(ctr_y));
    case (r.action)
      ACT_ADD: if (r.rotating_flag) member_bits[r.particle_id] = 1'b1;
      ACT_REMOVE: member_bits[r.particle_id] = 1'b0;
      ACT_POSITION: begin
        if (!rot) begin
          u.pos_x = r.new_x;
          u.pos_y = r.new_y;
        end else if (moved_bits[r.particle_id]) begin
          u.pos_x = r.cur_x;
          u.pos_y = r.cur_y;
        end else begin
          u.pos_x = clamp32(widen(ctr_x) + rotate_row(m00, dx, m01, dy));
          u.pos_y = clamp32(widen(ctr_y) + rotate_row(m10, dx, m11, dy));
          moved_bits[r.particle_id] = 1'b1;
        end
      end
      ACT_VELOCITY: begin
        if (!rot) begin
          u.vel_x = r.new_vx;
          u.vel_y = r.new_vy;
        end else begin
          u.vel_x = clamp32(-scale_q16(omega, dy));
          u.vel_y = clamp32(scale_q16(omega, dx));
        end
      end
      ACT_ENERGY: u.energy_out = rot ? r.old_energy : r.new_energy;
      ACT_INTERACT: u.may_interact = !(rot && member_bits[r.other_id]);
      ACT_NEW_STEP: foreach (moved_bits[i]) moved_bits[i] = 1'b0;
      default: ;
    endcase
    u.is_rotating = member_bits[r.particle_id];
    u.context_code = member_bits[r.particle_id];
    return u;
  endfunction

  function automatic void check_field(input string name, input logic signed [31:0] exp_v,
                                      input logic signed [31:0] got);
    if (exp_v !== got) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    if (result_valid && !result_stall) begin
      if (expected_updates.size() == 0) begin
        $error("result with no request pending");
        mismatches++;
      end else begin
        want = expected_updates.pop_front();
        check_field("pos_x", want.pos_x, pos_x);
        check_field("pos_y", want.pos_y, pos_y);
        check_field("vel_x", want.vel_x, vel_x);
        check_field("vel_y", want.vel_y, vel_y);
        check_field("energy_out", want.energy_out, energy_out);
        check_field("is_rotating", want.is_rotating, is_rotating);
        check_field("may_interact", want.may_interact, may_interact);
        check_field("context_code", want.context_code, context_code);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_CENTER_X: ctr_x = value;
      REG_CENTER_Y: ctr_y = value;
      REG_ROT_M00: m00 = value;
      REG_ROT_M01: m01 = value;
      REG_ROT_M10: m10 = value;
      REG_ROT_M11: m11 = value;
      REG_OMEGA: omega = value;
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_request(input request_t r);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    action <= r.action;
    particle_id <= r.particle_id;
    other_id <= r.other_id;
    rotating_flag <= r.rotating_flag;
    cur_x <= r.cur_x;
    cur_y <= r.cur_y;
    new_x <= r.new_x;
    new_y <= r.new_y;
    new_vx <= r.new_vx;
    new_vy <= r.new_vy;
    new_energy <= r.new_energy;
    old_energy <= r.old_energy;
    do @(posedge clk); while (item_stall !== 1'b0);
    expected_updates.push_back(predict_update(r));
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic request_t blank_request(input action_t act, input logic [11:0] id);
    request_t r;
    r = '{action: act, default: '0};
    r.particle_id = id;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(9))
      0: return Q_HI;
      1: return Q_LO;
      2, 3, 4: return $signed($urandom) >>> 12;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic logic [11:0] rand_id();
    if ($urandom_range(99) < 85) return id_pool[$urandom_range(15)];
    return 12'($urandom);
  endfunction

  function automatic request_t rand_request();
    request_t r;
    int pick;
    pick = $urandom_range(999);
    if (pick < 150) r.action = ACT_ADD;
    else if (pick < 200) r.action = ACT_REMOVE;
    else if (pick < 500) r.action = ACT_POSITION;
    else if (pick < 680) r.action = ACT_VELOCITY;
    else if (pick < 780) r.action = ACT_ENERGY;
    else if (pick < 880) r.action = ACT_INTERACT;
    else if (pick < 990) r.action = ACT_CONTEXT;
    else r.action = ACT_NEW_STEP;
    r.particle_id = rand_id();
    r.other_id = rand_id();
    r.rotating_flag = ($urandom_range(9) < 8);
    r.cur_x = rand_q16();
    r.cur_y = rand_q16();
    r.new_x = rand_q16();
    r.new_y = rand_q16();
    r.new_vx = rand_q16();
    r.new_vy = rand_q16();
    r.new_energy = rand_q16();
    r.old_energy = rand_q16();
    return r;
  endfunction

  function automatic logic [31:0] reg_value(input int kind, input int shift);
    case (kind)
      0: return $signed($urandom) >>> shift;
      1: return Q_HI;
      2: return Q_LO;
      default: return $urandom;
    endcase
  endfunction

  task automatic program_regs(input int kind);
    write_reg(REG_CENTER_X, reg_value(kind, 8));
    write_reg(REG_CENTER_Y, reg_value(kind, 8));
    write_reg(REG_ROT_M00, reg_value(kind, 1));
    write_reg(REG_ROT_M01, reg_value(kind, 1));
    write_reg(REG_ROT_M10, reg_value(kind, 1));
    write_reg(REG_ROT_M11, reg_value(kind, 1));
    write_reg(REG_OMEGA, reg_value(kind, 8));
  endtask

  task automatic test_directed();
    request_t r;
    send_request(blank_request(ACT_CONTEXT, 12'd0));
    r = blank_request(ACT_ADD, 12'd0);
    send_request(r);
    r = blank_request(ACT_ADD, 12'hfff);
    r.rotating_flag = 1'b1;
    send_request(r);
    r.particle_id = 12'd0;
    send_request(r);
    r = blank_request(ACT_INTERACT, 12'd0);
    r.other_id = 12'hfff;
    send_request(r);
    r.other_id = 12'd5;
    send_request(r);
    r = blank_request(ACT_POSITION, 12'd5);
    r.new_x = Q_HI;
    r.new_y = Q_LO;
    send_request(r);
    r = blank_request(ACT_POSITION, 12'hfff);
    r.cur_x = Q_LO;
    r.cur_y = Q_HI;
    r.new_x = 32'sd77;
    send_request(r);
    r.cur_x = 32'sd12345;
    send_request(r);
    r = blank_request(ACT_VELOCITY, 12'd5);
    r.new_vx = Q_LO;
    r.new_vy = Q_HI;
    send_request(r);
    r.particle_id = 12'hfff;
    send_request(r);
    r = blank_request(ACT_ENERGY, 12'hfff);
    r.new_energy = Q_HI;
    r.old_energy = Q_LO;
    send_request(r);
    r.particle_id = 12'd5;
    send_request(r);
    send_request(blank_request(ACT_NEW_STEP, 12'd0));
    r = blank_request(ACT_POSITION, 12'hfff);
    r.cur_x = 32'sd65536;
    r.cur_y = -32'sd1;
    send_request(r);
    send_request(blank_request(ACT_REMOVE, 12'hfff));
    send_request(blank_request(ACT_CONTEXT, 12'hfff));
    drain();

    program_regs(1);
    write_reg(REG_CENTER_Y, Q_LO);
    write_reg(REG_ROT_M00, Q_LO);
    write_reg(REG_ROT_M11, Q_LO);
    write_reg(REG_UNUSED, 32'h5a5a_5a5a);
    r = blank_request(ACT_POSITION, 12'd0);
    r.cur_x = Q_LO;
    r.cur_y = Q_HI;
    send_request(r);
    r.action = ACT_VELOCITY;
    send_request(r);
    send_request(blank_request(ACT_NEW_STEP, 12'd0));
    r = blank_request(ACT_POSITION, 12'd0);
    send_request(r);
    drain();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 8; phase++) begin
      case ((phase / 2) % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 51; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 51; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      program_regs(phase % 4);
      id_pool[0] = 12'd0;
      id_pool[1] = 12'hfff;
      for (int i = 2; i < 16; i++) id_pool[i] = 12'($urandom);
      for (int n = 0; n < 250; n++) send_request(rand_request());
      drain();
      stall_pct = 0;
      idle_pct = 0;
    end
  endtask

  initial begin
    ctr_x = '0;
    ctr_y = '0;
    m00 = 32'sh4000_0000;
    m01 = '0;
    m10 = '0;
    m11 = 32'sh4000_0000;
    omega = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (item_stall !== 1'b0);
    test_directed();
    test_random();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rbpu_pkg.sv
rtl/rbpu_bitmap.sv
rtl/rbpu_alu.sv
rtl/rotating_body_particle_update_unit.sv
rtl/rbpu_checker.sv
verif/rotating_body_particle_update_unit_tb.sv
